>>> hw/rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and constants of the nearest point search block
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    localparam int COUNT_W   = 11;
    localparam int SLOT_W    = 10;
    localparam int DIST_W    = 52;
    localparam int POS_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIST_W-1:0] RADIUS_RESET = 52'd163840000;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 1'b1;

    typedef enum logic [2:0] {
        AX_X = 3'b001,
        AX_Y = 3'b010,
        AX_Z = 3'b100
    } axis_t;

endpackage

`default_nettype wire

>>> hw/rtl/nearest_point_search_top.sv
// ----------------------------------------------------------------------------
// nearest_point_search_top
// linear nearest node search by squared euclidean distance over a node store
// ----------------------------------------------------------------------------
// A load transaction writes one node position and busy stays low. A query
// scans nodes 0 to node_count-1 (capped at MAX_NODES) with one shared squarer
// that handles one axis per cycle, stepping each node through the states X,
// Y, Z, A and C while busy is high; the result strobe done rises in the cycle
// in which busy falls, or in the cycle after the start when the capped count is zero.
// done is high for exactly one cycle and the receiver cannot stall it. The
// node store has no reset; every node a query scans must have been loaded.
`default_nettype none

module nearest_point_search_top
    import nps_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   kind,
    input  wire logic [SLOT_W-1:0]      node_slot,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    output logic                        done,
    output logic                        found,
    output logic [SLOT_W-1:0]           nearest_index,
    output logic [DIST_W-1:0]           best_dist_sq,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DIST_W-1:0]      cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int MEM_W  = 3 * COORD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_X    = 6'b000010,
        ST_Y    = 6'b000100,
        ST_Z    = 6'b001000,
        ST_A    = 6'b010000,
        ST_C    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [COUNT_W-1:0]  node_count_reg, node_count_next;
    logic [DIST_W-1:0]   radius_reg, radius_next;

    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]    n_eff_reg, n_eff_next;
    logic [MEM_W-1:0]    query_reg, query_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic [DIST_W-1:0]   acc_reg, acc_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   index_reg, index_next;
    logic [DIST_W-1:0]   dist_out_reg, dist_out_next;

    logic                start_acc;
    logic                wr_en;
    logic [MEM_W-1:0]    in_pos;
    logic [MEM_W-1:0]    node_pos;
    logic [CMP_W-1:0]    lim_wide;
    logic [CMP_W-1:0]    nc_wide;
    logic [CNT_W-1:0]    n_calc;
    logic                last_node;
    logic [SQ_W-1:0]     sq;
    axis_t               axis;
    logic [DIST_W-1:0]   node_dist;
    logic [DIST_W-1:0]   best_upd;
    logic [ADDR_W-1:0]   idx_upd;
    logic                hit_upd;

    assign start_acc = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_pos    = {pos_z[CB-1:0], pos_y[CB-1:0], pos_x[CB-1:0]};
    assign lim_wide  = CMP_W'(MAX_NODES);
    assign nc_wide   = CMP_W'(node_count_reg);
    assign n_calc    = (nc_wide > lim_wide) ? lim_wide[CNT_W-1:0] : nc_wide[CNT_W-1:0];
    assign wr_en     = start_acc && (kind == KIND_LOAD) && (CMP_W'(node_slot) < lim_wide);
    assign last_node = ((CNT_W'(scan_reg) + CNT_W'(1)) == n_eff_reg);

    nps_node_mem #(
        .DEPTH  (MAX_NODES),
        .WIDTH  (MEM_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(node_slot)),
        .wr_data (in_pos),
        .rd_addr (scan_next),
        .rd_data (node_pos)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_Y:    axis = AX_Y;
            ST_Z:    axis = AX_Z;
            default: axis = AX_X;
        endcase
    end

    nps_sq_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_sq (
        .clk       (clk),
        .axis      (axis),
        .node_pos  (node_pos),
        .query_pos (query_reg),
        .sq        (sq)
    );

    // config writes
    always_comb
    begin
        node_count_next = node_count_reg;
        radius_next     = radius_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_data[COUNT_W-1:0];
                CFG_RADIUS:     radius_next     = cfg_data;
            endcase
        end
    end

    // scan sequencer
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        scan_next     = scan_reg;
        n_eff_next    = n_eff_reg;
        query_next    = query_reg;
        best_next     = best_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        index_next    = index_reg;
        dist_out_next = dist_out_reg;
        node_dist     = acc_reg + DIST_W'(sq);
        best_upd      = best_reg;
        idx_upd       = idx_reg;
        hit_upd       = hit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_acc && (kind == KIND_QUERY))
                begin
                    scan_next  = '0;
                    n_eff_next = n_calc;
                    query_next = in_pos;
                    best_next  = radius_reg;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if (n_calc == '0)
                    begin
                        done_next     = 1'b1;
                        found_next    = 1'b0;
                        index_next    = '0;
                        dist_out_next = radius_reg;
                    end
                    else
                    begin
                        state_next = ST_X;
                    end
                end
            end
            ST_X:
            begin
                state_next = ST_Y;
            end
            ST_Y:
            begin
                state_next = ST_Z;
            end
            ST_Z:
            begin
                acc_next   = DIST_W'(sq);
                state_next = ST_A;
            end
            ST_A:
            begin
                acc_next   = acc_reg + DIST_W'(sq);
                state_next = ST_C;
            end
            ST_C:
            begin
                if (node_dist < best_reg)
                begin
                    best_upd = node_dist;
                    idx_upd  = scan_reg;
                    hit_upd  = 1'b1;
                end
                best_next = best_upd;
                idx_next  = idx_upd;
                hit_next  = hit_upd;
                if (last_node)
                begin
                    state_next    = ST_IDLE;
                    done_next     = 1'b1;
                    found_next    = hit_upd;
                    index_next    = hit_upd ? SLOT_W'(idx_upd) : '0;
                    dist_out_next = best_upd;
                end
                else
                begin
                    scan_next  = scan_reg + ADDR_W'(1);
                    state_next = ST_X;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            node_count_reg <= '0;
            radius_reg     <= RADIUS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            node_count_reg <= node_count_next;
            radius_reg     <= radius_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        n_eff_reg    <= n_eff_next;
        query_reg    <= query_next;
        best_reg     <= best_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        index_reg    <= index_next;
        dist_out_reg <= dist_out_next;
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign nearest_index = index_reg;
    assign best_dist_sq  = dist_out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/nps_node_mem.sv
// ----------------------------------------------------------------------------
// nps_node_mem
// node position store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module nps_node_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 72,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/nps_sq_unit.sv
// ----------------------------------------------------------------------------
// nps_sq_unit
// shared squared difference unit, one axis per cycle, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

module nps_sq_unit
    import nps_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                      clk,
    input  wire axis_t                     axis,
    input  wire logic [3*COORD_BITS-1:0]   node_pos,
    input  wire logic [3*COORD_BITS-1:0]   query_pos,
    output logic      [2*COORD_BITS-1:0]   sq
);

    localparam int CB   = COORD_BITS;
    localparam int SQ_W = 2 * COORD_BITS;

    logic [CB-1:0]     op_a;
    logic [CB-1:0]     op_b;
    logic signed [CB:0] diff;
    logic signed [CB:0] diff_neg;
    logic [CB-1:0]     mag;
    logic [CB-1:0]     mag_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   sq_next;

    always_comb
    begin
        unique case (axis)
            AX_X:
            begin
                op_a = node_pos[CB-1:0];
                op_b = query_pos[CB-1:0];
            end
            AX_Y:
            begin
                op_a = node_pos[2*CB-1:CB];
                op_b = query_pos[2*CB-1:CB];
            end
            AX_Z:
            begin
                op_a = node_pos[3*CB-1:2*CB];
                op_b = query_pos[3*CB-1:2*CB];
            end
            default:
            begin
                op_a = node_pos[CB-1:0];
                op_b = query_pos[CB-1:0];
            end
        endcase
    end

    assign diff     = $signed({op_a[CB-1], op_a}) - $signed({op_b[CB-1], op_b});
    assign diff_neg = -diff;
    assign mag      = diff[CB] ? diff_neg[CB-1:0] : diff[CB-1:0];
    assign sq_next  = SQ_W'(mag_reg) * SQ_W'(mag_reg);

    always_ff @(posedge clk)
    begin
        mag_reg <= mag;
        sq_reg  <= sq_next;
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the nearest point search block: a directed table of
// loads, queries and register writes, then random phases of node loads
// followed by queries mostly near stored nodes, each query result compared
// field by field against a typed table answer or a local nearest node scan
// ----------------------------------------------------------------------------

module testbench;

    import nps_pkg::*;

    localparam int NODE_SLOTS  = 1024;
    localparam int RANDOM_ITEMS = 560;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PLAN_ROWS   = 22;

    localparam logic [POS_W-1:0]  C_MIN    = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0]  C_MAX    = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] FAR_SQ   = 52'd844424829468675;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] node;
        logic [DIST_W-1:0] dist_sq;
    } search_result_t;

    localparam search_result_t NO_ANSWER     = '0;
    localparam search_result_t MISS_AT_RESET = {1'b0, {SLOT_W{1'b0}}, RADIUS_RESET};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_QUERY,
        ST_CFG
    } step_op_t;

    typedef struct {
        step_op_t          op;
        int unsigned       idx;
        logic [POS_W-1:0]  x, y, z;
        logic [DIST_W-1:0] data;
        bit                typed;
        search_result_t    answer;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  kind;
    logic [SLOT_W-1:0]     node_slot;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [POS_W-1:0]      pos_z;
    logic                  done;
    logic                  found;
    logic [SLOT_W-1:0]     nearest_index;
    logic [DIST_W-1:0]     best_dist_sq;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIST_W-1:0]     cfg_data;

    logic signed [POS_W-1:0] node_x [NODE_SLOTS];
    logic signed [POS_W-1:0] node_y [NODE_SLOTS];
    logic signed [POS_W-1:0] node_z [NODE_SLOTS];
    bit                      loaded [NODE_SLOTS];
    logic [COUNT_W-1:0]      scan_count;
    logic [DIST_W-1:0]       scan_radius;

    search_result_t nearest_pending [$];
    search_result_t typed_answer;
    search_result_t answer;
    search_result_t oldest;
    bit             typed_valid;
    plan_row_t      plan [PLAN_ROWS];
    logic [DIST_W-1:0] reg_word;

    int fail_count;
    int cycle_count;
    int load_count;
    int query_count;
    int hit_count;
    int write_count;
    int widest_scan;

    nearest_point_search_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .node_slot     (node_slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .done          (done),
        .found         (found),
        .nearest_index (nearest_index),
        .best_dist_sq  (best_dist_sq),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic search_result_t scan_nearest(input logic signed [POS_W-1:0] qx,
                                                    input logic signed [POS_W-1:0] qy,
                                                    input logic signed [POS_W-1:0] qz);
        search_result_t    r;
        int                n;
        longint            dx, dy, dz;
        logic [DIST_W-1:0] d;
        n = (scan_count > NODE_SLOTS) ? NODE_SLOTS : int'(scan_count);
        r.hit     = 1'b0;
        r.node    = '0;
        r.dist_sq = scan_radius;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(node_x[i]) - longint'(qx);
            dy = longint'(node_y[i]) - longint'(qy);
            dz = longint'(node_z[i]) - longint'(qz);
            d  = DIST_W'(dx * dx + dy * dy + dz * dz);
            if (d < r.dist_sq)
            begin
                r.hit     = 1'b1;
                r.node    = SLOT_W'(i);
                r.dist_sq = d;
            end
        end
        return r;
    endfunction

    function automatic int loaded_prefix();
        int n = 0;
        while (n < NODE_SLOTS && loaded[n])
            n++;
        return n;
    endfunction

    function automatic logic [POS_W-1:0] rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0:       v = -(1 << (POS_W - 1));
            1:       v = (1 << (POS_W - 1)) - 1;
            2, 3:    v = int'($urandom);
            4:       v = $urandom_range(0, 131071) - 65536;
            default: v = $urandom_range(0, 4095) - 2048;
        endcase
        return v[POS_W-1:0];
    endfunction

    // scoreboard and predictor update, all sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (nearest_pending.size() == 0)
                begin
                    $error("result transaction with no query pending");
                    fail_count++;
                end
                else
                begin
                    oldest = nearest_pending.pop_front();
                    if (found !== oldest.hit)
                    begin
                        $error("found: expected %0d, actual %0d", oldest.hit, found);
                        fail_count++;
                    end
                    if (nearest_index !== oldest.node)
                    begin
                        $error("nearest_index: expected %0d, actual %0d",
                               oldest.node, nearest_index);
                        fail_count++;
                    end
                    if (best_dist_sq !== oldest.dist_sq)
                    begin
                        $error("best_dist_sq: expected %0d, actual %0d",
                               oldest.dist_sq, best_dist_sq);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                write_count++;
                case (cfg_index)
                    CFG_NODE_COUNT:
                    begin
                        scan_count = cfg_data[COUNT_W-1:0];
                        if (int'(scan_count) > widest_scan)
                            widest_scan = int'(scan_count);
                    end
                    CFG_RADIUS:
                        scan_radius = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (kind == KIND_LOAD)
                begin
                    load_count++;
                    node_x[node_slot] = pos_x;
                    node_y[node_slot] = pos_y;
                    node_z[node_slot] = pos_z;
                    loaded[node_slot] = 1'b1;
                end
                else
                begin
                    query_count++;
                    answer = typed_valid ? typed_answer : scan_nearest(pos_x, pos_y, pos_z);
                    if (answer.hit)
                        hit_count++;
                    nearest_pending.push_back(answer);
                end
            end
        end
    end

    task automatic send_item(input logic k, input logic [SLOT_W-1:0] s,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z, input bit has_typed,
                             input search_result_t typed);
        @(negedge clk);
        start     <= 1'b1;
        kind      <= k;
        node_slot <= s;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        typed_valid  = has_typed;
        typed_answer = typed;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // hold off until every query has answered and the block is quiet
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (nearest_pending.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random();
        int s;
        int pick;
        pick = $urandom_range(0, 9);
        s = loaded_prefix();
        if (s >= NODE_SLOTS || pick >= 5)
            s = (pick < 8 && s > 0) ? $urandom_range(0, s - 1) : $urandom_range(0, NODE_SLOTS - 1);
        send_item(KIND_LOAD, s[SLOT_W-1:0], rand_coord(), rand_coord(), rand_coord(),
                  1'b0, NO_ANSWER);
    endtask

    task automatic query_random(input int n);
        int               i;
        logic [POS_W-1:0] x, y, z;
        if (n > 0 && $urandom_range(0, 3) != 0)
        begin
            i = $urandom_range(0, n - 1);
            x = node_x[i] + POS_W'($urandom_range(0, 16) - 8);
            y = node_y[i] + POS_W'($urandom_range(0, 16) - 8);
            z = node_z[i] + POS_W'($urandom_range(0, 16) - 8);
        end
        else
        begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
        end
        send_item(KIND_QUERY, SLOT_W'($urandom), x, y, z, 1'b0, NO_ANSWER);
    endtask

    initial
    begin
        int  cnt;
        int  pref;
        int  n_load;
        int  n_ask;
        int  random_items;
        bit  quiet;

        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_LOAD;
        node_slot   = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NODE_COUNT;
        cfg_data    = '0;
        typed_valid = 1'b0;
        typed_answer = NO_ANSWER;
        scan_count  = '0;
        scan_radius = RADIUS_RESET;
        fail_count  = 0;
        cycle_count = 0;
        load_count  = 0;
        query_count = 0;
        hit_count   = 0;
        write_count = 0;
        widest_scan = 0;
        random_items = 0;

        plan = '{
            '{ST_QUERY, 0,    0, 0, 0, 0, 1'b1, MISS_AT_RESET},
            '{ST_QUERY, 1023, 5, 5, 5, 0, 1'b1, MISS_AT_RESET},
            '{ST_LOAD,  0,    0, 0, 0, 0, 1'b0, NO_ANSWER},
            '{ST_LOAD,  1,    0, 0, 0, 0, 1'b0, NO_ANSWER},
            '{ST_LOAD,  2,    16, -16, 32, 0, 1'b0, NO_ANSWER},
            '{ST_LOAD,  1023, C_MAX, C_MAX, C_MAX, 0, 1'b0, NO_ANSWER},
            '{ST_CFG,   CFG_NODE_COUNT, 0, 0, 0, 3, 1'b0, NO_ANSWER},
            '{ST_QUERY, 0,    0, 0, 0, 0, 1'b1, {1'b1, 10'd0, 52'd0}},
            '{ST_QUERY, 0,    16, -16, 32, 0, 1'b1, {1'b1, 10'd2, 52'd0}},
            '{ST_QUERY, 0,    12800, 0, 0, 0, 1'b0, NO_ANSWER},
            '{ST_QUERY, 0,    C_MIN, C_MIN, C_MIN, 0, 1'b1, MISS_AT_RESET},
            '{ST_CFG,   CFG_RADIUS, 0, 0, 0, 0, 1'b0, NO_ANSWER},
            '{ST_QUERY, 0,    0, 0, 0, 0, 1'b1, {1'b0, 10'd0, 52'd0}},
            '{ST_CFG,   CFG_RADIUS, 0, 0, 0, DIST_MAX, 1'b0, NO_ANSWER},
            '{ST_LOAD,  0,    C_MIN, C_MIN, C_MIN, 0, 1'b0, NO_ANSWER},
            '{ST_CFG,   CFG_NODE_COUNT, 0, 0, 0, 1, 1'b0, NO_ANSWER},
            '{ST_QUERY, 0,    C_MAX, C_MAX, C_MAX, 0, 1'b1, {1'b1, 10'd0, FAR_SQ}},
            '{ST_QUERY, 0,    C_MIN, C_MIN, C_MIN, 0, 1'b1, {1'b1, 10'd0, 52'd0}},
            '{ST_LOAD,  0,    0, 0, 0, 0, 1'b0, NO_ANSWER},
            '{ST_CFG,   CFG_NODE_COUNT, 0, 0, 0, 3, 1'b0, NO_ANSWER},
            '{ST_CFG,   CFG_RADIUS, 0, 0, 0, RADIUS_RESET, 1'b0, NO_ANSWER},
            '{ST_QUERY, 0,    -7, 100, -3, 0, 1'b0, NO_ANSWER}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].op == ST_CFG)
            begin
                settle();
                cfg_write(CFG_IDX_W'(plan[r].idx), plan[r].data);
            end
            else
                send_item((plan[r].op == ST_LOAD) ? KIND_LOAD : KIND_QUERY,
                          SLOT_W'(plan[r].idx), plan[r].x, plan[r].y, plan[r].z,
                          plan[r].typed, plan[r].answer);
        end

        // random phases: a run of loads, then queries against the scanned prefix
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            pref = loaded_prefix();
            if (pref == 0 || $urandom_range(0, 9) == 0)
                cnt = 0;
            else
                cnt = $urandom_range(1, (pref < 40) ? pref : 40);
            reg_word = DIST_W'({$urandom, $urandom});
            reg_word[COUNT_W-1:0] = COUNT_W'(cnt);
            cfg_write(CFG_NODE_COUNT, reg_word);
            case ($urandom_range(0, 7))
                0:       reg_word = '0;
                1:       reg_word = DIST_MAX;
                2:       reg_word = DIST_W'({$urandom, $urandom});
                3:       reg_word = DIST_W'($urandom_range(0, 1 << 20));
                4:       reg_word = DIST_W'(64'($urandom) << $urandom_range(0, 18));
                default: reg_word = RADIUS_RESET;
            endcase
            cfg_write(CFG_RADIUS, reg_word);
            quiet  = ($urandom_range(0, 3) == 0) || (random_items > RANDOM_ITEMS - 60);
            n_load = $urandom_range(2, 12);
            n_ask  = $urandom_range(12, 30);
            for (int j = 0; j < n_load + n_ask; j++)
            begin
                if (j < n_load || $urandom_range(0, 9) == 0)
                    load_random();
                else
                    query_random(cnt);
                random_items++;
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle($urandom_range(1, 8));
            end
        end

        // scan the whole loaded prefix with the widest radius
        settle();
        pref = loaded_prefix();
        cfg_write(CFG_NODE_COUNT, DIST_W'(pref));
        cfg_write(CFG_RADIUS, DIST_MAX);
        query_random(pref);
        query_random(pref);

        settle();
        repeat (16) @(posedge clk);

        $display("covered %0d node loads, %0d queries (%0d hits) and %0d register writes",
                 load_count, query_count, hit_count, write_count);
        $display("scans up to %0d nodes over %0d loaded slots, radius from zero to full scale",
                 widest_scan, loaded_prefix());
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/nps_pkg.sv
hw/rtl/nps_node_mem.sv
hw/rtl/nps_sq_unit.sv
hw/rtl/nearest_point_search_top.sv
tb/testbench.sv
